@@ hdl/tnfc_pkg.sv @@
// shared types, constants and byte classes for the text normalizer
`default_nettype none
package tnfc_pkg;

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = 2;

  typedef enum logic [1:0] {
    REG_FOLD_CASE        = 2'd0,
    REG_DROP_PUNCTUATION = 2'd1,
    REG_COLLAPSE_SPACE   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  byte_val;
    logic [15:0] index;
    logic        carries;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b >= 8'd9 && b <= 8'd13) || b == SPACE_BYTE;
  endfunction

  function automatic logic is_symbol(input logic [7:0] b);
    return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
           (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
  endfunction

endpackage
`default_nettype wire

@@ hdl/text_normalize_fold_collapse_unit.sv @@
// text normalizer: case fold, punctuation drop, whitespace collapse, trailing trim
// Usage:
//   in_*   : one source byte per transfer (in_valid / in_stall), with in_end_of_input
//            on the final byte of a string.
//   out_*  : normalized bytes with their source index; the last result of a string has
//            out_end_of_output set, a bare end marker has out_carries_byte low.
//   cfg_*  : register writes (index 0 fold case, 1 drop punctuation, 2 collapse space),
//            bit 0 of cfg_data is stored; cfg_ready is always high.
// Each result passes the input register and the result queue before it is offered.
// The last kept byte is held back until the next kept byte or the end of the string.
// Throughput: one byte per cycle unless in_stall; a byte yielding two results enters
// the four-entry queue in one write; it drains one result per cycle unless stalled.
// The input stage stalls only when the queue has fewer than two free entries.
// Reset clears the registers, the held byte, the position and the queue.
// When the receiver stalls, the queue head holds and the input side keeps taking
// bytes until fewer than two queue entries are free.
`default_nettype none
module text_normalize_fold_collapse_unit #(
  parameter longint unsigned MAX_LEN = 65536
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_byte,
  input  wire         in_end_of_input,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_byte,
  output logic [15:0] out_source_index,
  output logic        out_carries_byte,
  output logic        out_end_of_output,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire         cfg_data
);
  import tnfc_pkg::*;

  localparam int unsigned PW = $clog2(MAX_LEN);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_LEN - 1);

  logic          fold_r, drop_r, coll_r;
  logic          s_vld_r, s_vld_nxt;
  logic [7:0]    s_byte_r;
  logic          s_eoi_r;
  logic          run_r, run_nxt;
  logic          hv_r, hv_nxt;
  logic [7:0]    hb_r, hb_nxt;
  logic [15:0]   hi_r, hi_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [63:0]   pos_ext;
  logic          go, accept, kept;
  logic [7:0]    kb;
  logic          hv1;
  logic [7:0]    hb1;
  logic [15:0]   hi1;
  result_t       prev_res, final_res;
  push_t         push;
  logic [2:0]    q_count;
  result_t       head;

  assign cfg_ready = 1'b1;
  assign go        = s_vld_r && q_count <= 3'(QDEPTH - 2);
  assign in_stall  = s_vld_r && !go;
  assign accept    = in_valid && !in_stall;
  assign pos_ext   = 64'(pos_r);

  always_comb begin
    kept    = 1'b0;
    kb      = 8'd0;
    run_nxt = run_r;
    if (coll_r && is_ws(s_byte_r)) begin
      if (!run_r) begin
        kept    = 1'b1;
        kb      = SPACE_BYTE;
        run_nxt = 1'b1;
      end
    end else if (drop_r && is_symbol(s_byte_r)) begin
      kept = 1'b0;
    end else begin
      kept    = 1'b1;
      kb      = (fold_r && s_byte_r >= 8'h61 && s_byte_r <= 8'h7a) ?
                (s_byte_r - 8'h20) : s_byte_r;
      run_nxt = 1'b0;
    end

    hv1 = kept || hv_r;
    hb1 = kept ? kb : hb_r;
    hi1 = kept ? pos_ext[15:0] : hi_r;

    prev_res = '{byte_val: hb_r, index: hi_r, carries: 1'b1, last: 1'b0};
    if (hv1 && hb1 != SPACE_BYTE) begin
      final_res = '{byte_val: hb1, index: hi1, carries: 1'b1, last: 1'b1};
    end else begin
      final_res = '{byte_val: 8'd0, index: 16'd0, carries: 1'b0, last: 1'b1};
    end

    push.num = 2'd0;
    push.r0  = final_res;
    push.r1  = final_res;
    if (go) begin
      if (kept && hv_r) begin
        push.r0  = prev_res;
        push.num = s_eoi_r ? 2'd2 : 2'd1;
      end else begin
        push.num = s_eoi_r ? 2'd1 : 2'd0;
      end
    end

    hv_nxt  = hv_r;
    hb_nxt  = hb_r;
    hi_nxt  = hi_r;
    pos_nxt = pos_r;
    if (go) begin
      if (s_eoi_r) begin
        run_nxt = 1'b0;
        hv_nxt  = 1'b0;
        hb_nxt  = 8'd0;
        hi_nxt  = 16'd0;
        pos_nxt = '0;
      end else begin
        hv_nxt  = hv1;
        hb_nxt  = hb1;
        hi_nxt  = hi1;
        pos_nxt = (pos_r < POS_MAX) ? pos_r + PW'(1) : pos_r;
      end
    end else begin
      run_nxt = run_r;
    end

    s_vld_nxt = accept ? 1'b1 : (go ? 1'b0 : s_vld_r);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_byte_r <= in_byte;
      s_eoi_r  <= in_end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r  <= 1'b0;
      drop_r  <= 1'b0;
      coll_r  <= 1'b0;
      s_vld_r <= 1'b0;
      run_r   <= 1'b0;
      hv_r    <= 1'b0;
      hb_r    <= 8'd0;
      hi_r    <= 16'd0;
      pos_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FOLD_CASE:        fold_r <= cfg_data;
          REG_DROP_PUNCTUATION: drop_r <= cfg_data;
          REG_COLLAPSE_SPACE:   coll_r <= cfg_data;
          default:              ;
        endcase
      end
      s_vld_r <= s_vld_nxt;
      run_r   <= run_nxt;
      hv_r    <= hv_nxt;
      hb_r    <= hb_nxt;
      hi_r    <= hi_nxt;
      pos_r   <= pos_nxt;
    end
  end

  tnfc_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .count     (q_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_byte          = head.byte_val;
  assign out_source_index  = head.index;
  assign out_carries_byte  = head.carries;
  assign out_end_of_output = head.last;

`ifndef NO_ASSERTIONS
  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && s_eoi_r |=> !hv_r && !run_r && pos_r == '0)
    else $error("string end did not return state to idle");
  a_run_held: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> hv_r && hb_r == SPACE_BYTE)
    else $error("space run without held space");
  a_pos_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(pos_r) && $stable(hv_r))
    else $error("state moved while input stage stalled");
`endif

endmodule
`default_nettype wire

@@ hdl/tnfc_result_queue.sv @@
// four-entry result queue taking up to two results per cycle
`default_nettype none
module tnfc_result_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  tnfc_pkg::push_t        push,
  output logic [2:0]             count,
  output logic                   out_valid,
  input  wire                    out_stall,
  output tnfc_pkg::result_t      head
);
  import tnfc_pkg::*;

  result_t        mem [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [2:0]     cnt_r, cnt_nxt;
  logic           pop;

  assign out_valid = cnt_r != 3'd0;
  assign pop       = out_valid && !out_stall;
  assign head      = mem[rp_r];
  assign count     = cnt_r;

  always_comb begin
    wp_nxt  = wp_r + QAW'(push.num);
    rp_nxt  = rp_r + QAW'(pop);
    cnt_nxt = cnt_r + 3'(push.num) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wp_r] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem[wp_r + QAW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(QDEPTH))
    else $error("queue count beyond depth");
  a_two_fit: assert property (@(posedge clk) disable iff (!rst_n)
    push.num == 2'd2 |-> cnt_r <= 3'(QDEPTH - 2))
    else $error("double push into full queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    push.num == 2'd0 && !pop |=> $stable(cnt_r))
    else $error("queue count moved without transfer");
`endif

endmodule
`default_nettype wire

@@ test/tb.sv @@
// testbench for the text normalizer: random byte strings checked against a behavioral predictor
`default_nettype none
module tb;
  import tnfc_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [7:0] b;
    logic       eoi;
  } src_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic [15:0] out_source_index;
  logic        out_carries_byte;
  logic        out_end_of_output;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic        cfg_data = 1'b0;

  src_byte_t   src_q[$];
  result_t     norm_due[$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned errors = 0;
  logic        byte_taken = 1'b0;

  // predictor state and register copies
  logic        fold_on = 1'b0;
  logic        drop_on = 1'b0;
  logic        collapse_on = 1'b0;
  logic        space_run = 1'b0;
  logic        held_v = 1'b0;
  logic [7:0]  held_b = 8'h00;
  logic [15:0] held_i = 16'h0000;
  logic [15:0] src_pos = 16'h0000;

  text_normalize_fold_collapse_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .in_end_of_input(in_end_of_input),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_source_index(out_source_index),
    .out_carries_byte(out_carries_byte),
    .out_end_of_output(out_end_of_output),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic normalize_byte(input logic [7:0] b, input logic eoi);
    logic        keep;
    logic        ws;
    logic        pn;
    logic [7:0]  kb;
    logic [15:0] idx;
    keep = 1'b0;
    kb = b;
    idx = src_pos;
    ws = (b >= 8'd9 && b <= 8'd13) || b == SPACE_BYTE;
    pn = (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
         (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
    if (src_pos != 16'hFFFF) src_pos = src_pos + 16'd1;
    if (collapse_on && ws) begin
      if (!space_run) begin
        keep = 1'b1;
        kb = SPACE_BYTE;
        space_run = 1'b1;
      end
    end else if (drop_on && pn) begin
      // dropped, a space run stays open
    end else begin
      keep = 1'b1;
      if (fold_on && b >= 8'h61 && b <= 8'h7A) kb = b - 8'h20;
      space_run = 1'b0;
    end
    if (keep) begin
      if (held_v) norm_due.push_back('{held_b, held_i, 1'b1, 1'b0});
      held_v = 1'b1;
      held_b = kb;
      held_i = idx;
    end
    if (eoi) begin
      if (held_v && held_b == SPACE_BYTE) held_v = 1'b0;
      if (held_v) norm_due.push_back('{held_b, held_i, 1'b1, 1'b1});
      else norm_due.push_back('{8'h00, 16'h0000, 1'b0, 1'b1});
      space_run = 1'b0;
      held_v = 1'b0;
      held_b = 8'h00;
      held_i = 16'h0000;
      src_pos = 16'h0000;
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
    end
  endtask

  // input transfers feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      normalize_byte(in_byte, in_end_of_input);
      void'(src_q.pop_front());
      byte_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (src_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_byte <= src_q[0].b;
        in_end_of_input <= src_q[0].eoi;
      end else begin
        in_valid <= 1'b0;
      end
    end
    byte_taken = 1'b0;
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (norm_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got byte %h index %h carries %b last %b",
                 $time, out_byte, out_source_index, out_carries_byte, out_end_of_output);
      end else begin
        want = norm_due.pop_front();
        check_field("out_byte", 32'(want.byte_val), 32'(out_byte));
        check_field("out_source_index", 32'(want.index), 32'(out_source_index));
        check_field("out_carries_byte", 32'(want.carries), 32'(out_carries_byte));
        check_field("out_end_of_output", 32'(want.last), 32'(out_end_of_output));
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FOLD_CASE:        fold_on = val;
      REG_DROP_PUNCTUATION: drop_on = val;
      REG_COLLAPSE_SPACE:   collapse_on = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (src_q.size() != 0 || norm_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0, 1: return $urandom_range(1) ? SPACE_BYTE : 8'($urandom_range(9, 13));
      2, 3: begin
        case ($urandom_range(3))
          0: return 8'($urandom_range(33, 47));
          1: return 8'($urandom_range(58, 64));
          2: return 8'($urandom_range(91, 96));
          default: return 8'($urandom_range(123, 126));
        endcase
      end
      4, 5: return 8'($urandom_range(8'h61, 8'h7A));
      6: return 8'($urandom_range(8'h41, 8'h5A));
      7: return 8'($urandom_range(8'h30, 8'h39));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_string(input int unsigned len, input logic terminate);
    for (int unsigned i = 0; i < len; i++)
      src_q.push_back('{pick_char(), terminate && i == len - 1});
  endtask

  task automatic add_bytes(input logic [7:0] s[$]);
    foreach (s[i]) src_q.push_back('{s[i], i == s.size() - 1});
  endtask

  task automatic random_block(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      // some strings run on into the next one without an end mark
      add_string(len, $urandom_range(9) != 0);
      sent += len;
    end
  endtask

  initial begin
    logic [2:0] mode;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 29;
    stall_pct = 59;
    // spare index must not change anything
    write_reg(REG_SPARE, 1'b1);
    // plain pass-through, only one of two trailing spaces trimmed
    add_bytes('{8'h00, 8'hFF, 8'h61, 8'h21, SPACE_BYTE, SPACE_BYTE});
    drain();
    write_reg(REG_FOLD_CASE, 1'b1);
    write_reg(REG_DROP_PUNCTUATION, 1'b1);
    write_reg(REG_COLLAPSE_SPACE, 1'b1);
    // whitespace run with punctuation inside, folding, trailing collapsed space
    add_bytes('{SPACE_BYTE, 8'h09, 8'h2E, 8'h0A, 8'h61, 8'h7A, 8'h60, 8'h7B,
                8'h41, 8'h40, 8'h5A, SPACE_BYTE});
    // strings that leave only the end marker, and one that leaves a folded letter
    add_bytes('{8'h23});
    add_bytes('{8'h0D});
    add_bytes('{8'h7E, 8'h6D});

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 59 : 0;
      stall_pct = (ph == 0) ? 59 : (ph == 1) ? 29 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        drain();
        if (ph == 0 && blk == 0) mode = 3'b000;
        else if (ph == 0 && blk == 1) mode = 3'b111;
        else mode = 3'($urandom_range(7));
        write_reg(REG_FOLD_CASE, mode[0]);
        write_reg(REG_DROP_PUNCTUATION, mode[1]);
        write_reg(REG_COLLAPSE_SPACE, mode[2]);
        if ($urandom_range(3) == 0) write_reg(REG_SPARE, 1'($urandom_range(1)));
        random_block(145);
      end
    end

    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
hdl/tnfc_pkg.sv
hdl/tnfc_result_queue.sv
hdl/text_normalize_fold_collapse_unit.sv
test/tb.sv
